// ----- rtl/lnat_pkg.sv -----
// ----------------------------------------------------------------------------
// lnat_pkg
// Shared constants for the atanh-series natural logarithm pipeline.
// ----------------------------------------------------------------------------
package lnat_pkg;

	localparam int unsigned OPERAND_BITS       = 16;
	localparam int unsigned LOG_BITS           = 27;
	localparam int unsigned FRAC_BITS_DEFAULT  = 24;
	localparam int unsigned INPUT_BITS_DEFAULT = 16;

	// Odd divisors of the series terms
	localparam int unsigned LEAD_DIV     = 15;
	localparam int unsigned HORNER_TERMS = 7;
	localparam int unsigned HORNER_DIV [HORNER_TERMS] = '{13, 11, 9, 7, 5, 3, 1};

endpackage

// ----- rtl/lnat_div_stage.sv -----
// ----------------------------------------------------------------------------
// lnat_div_stage
// One restoring division step: yields one quotient bit per register stage.
// ----------------------------------------------------------------------------
module lnat_div_stage #(
	parameter int unsigned Y_BITS    = 16,
	parameter int unsigned FRAC_BITS = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_stall,
	input  logic [Y_BITS:0]      rem_up,
	input  logic [Y_BITS:0]      den_up,
	input  logic [FRAC_BITS-1:0] quot_up,
	output logic                 dn_valid,
	input  logic                 dn_stall,
	output logic [Y_BITS:0]      rem_dn,
	output logic [Y_BITS:0]      den_dn,
	output logic [FRAC_BITS-1:0] quot_dn
);

	logic                 valid_s1;
	logic [Y_BITS:0]      rem_s1;
	logic [Y_BITS:0]      den_s1;
	logic [FRAC_BITS-1:0] quot_s1;
	logic [Y_BITS+1:0]    two_rem;
	logic [Y_BITS+2:0]    diff;
	logic                 ge;

	assign two_rem = {rem_up, 1'b0};
	assign diff    = {1'b0, two_rem} - (Y_BITS+3)'(den_up);
	assign ge      = ~diff[Y_BITS+2];

	assign up_stall = valid_s1 & dn_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!up_stall) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && !up_stall) begin
			rem_s1  <= ge ? diff[Y_BITS:0] : two_rem[Y_BITS:0];
			den_s1  <= den_up;
			quot_s1 <= {quot_up[FRAC_BITS-2:0], ge};
		end
	end

	assign dn_valid = valid_s1;
	assign rem_dn   = rem_s1;
	assign den_dn   = den_s1;
	assign quot_dn  = quot_s1;

endmodule

// ----- rtl/lnat_horner_stage.sv -----
// ----------------------------------------------------------------------------
// lnat_horner_stage
// One Horner step of the series: s = c + floor(t2 * s / 2^F).
// ----------------------------------------------------------------------------
module lnat_horner_stage #(
	parameter int unsigned FRAC_BITS = 24,
	parameter int unsigned DIVISOR   = 3
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 up_valid,
	output logic                 up_stall,
	input  logic [FRAC_BITS-1:0] t_up,
	input  logic [FRAC_BITS-1:0] t2_up,
	input  logic [FRAC_BITS+1:0] s_up,
	output logic                 dn_valid,
	input  logic                 dn_stall,
	output logic [FRAC_BITS-1:0] t_dn,
	output logic [FRAC_BITS-1:0] t2_dn,
	output logic [FRAC_BITS+1:0] s_dn
);

	localparam int unsigned S_BITS = FRAC_BITS + 2;
	localparam int unsigned P_BITS = FRAC_BITS + S_BITS;
	localparam logic [S_BITS-1:0] COEF = S_BITS'((64'd1 << FRAC_BITS) / DIVISOR);

	logic                 valid_s1;
	logic [FRAC_BITS-1:0] t_s1;
	logic [FRAC_BITS-1:0] t2_s1;
	logic [S_BITS-1:0]    s_s1;
	logic [P_BITS-1:0]    prod;
	logic [S_BITS-1:0]    s_next;

	assign prod   = P_BITS'(t2_up) * P_BITS'(s_up);
	assign s_next = COEF + prod[P_BITS-1:FRAC_BITS];

	assign up_stall = valid_s1 & dn_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!up_stall) begin
			valid_s1 <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_valid && !up_stall) begin
			t_s1  <= t_up;
			t2_s1 <= t2_up;
			s_s1  <= s_next;
		end
	end

	assign dn_valid = valid_s1;
	assign t_dn     = t_s1;
	assign t2_dn    = t2_s1;
	assign s_dn     = s_s1;

endmodule

// ----- rtl/natural_log_atanh_series.sv -----
// Throughput: one request per cycle; the FRAC_BITS-stage restoring divider yields one
// quotient bit per stage and each of the nine multiplier stages holds one product.
// Stalls back up stage by stage, so bubbles are squeezed out before input is stalled.
// Reset (arst_n low) clears every stage's valid flag at once; data registers are not reset.
// ----------------------------------------------------------------------------
// natural_log_atanh_series
// Natural logarithm of an unsigned integer by the 8-term atanh series,
// in unsigned fixed point with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
module natural_log_atanh_series #(
	parameter int unsigned FRAC_BITS  = lnat_pkg::FRAC_BITS_DEFAULT,
	parameter int unsigned INPUT_BITS = lnat_pkg::INPUT_BITS_DEFAULT
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [lnat_pkg::OPERAND_BITS-1:0] operand,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [lnat_pkg::LOG_BITS-1:0]   log_value
);

	import lnat_pkg::*;

	localparam int unsigned Y_BITS   = (INPUT_BITS < OPERAND_BITS) ? INPUT_BITS : OPERAND_BITS;
	localparam int unsigned S_BITS   = FRAC_BITS + 2;
	localparam int unsigned R_BITS   = FRAC_BITS + 3;
	localparam int unsigned SQ_BITS  = 2 * FRAC_BITS;
	localparam int unsigned FP_BITS  = FRAC_BITS + S_BITS + 1;
	localparam int unsigned W_BITS   = (R_BITS > LOG_BITS) ? R_BITS : LOG_BITS;
	localparam logic [S_BITS-1:0] C_LEAD = S_BITS'((64'd1 << FRAC_BITS) / LEAD_DIV);
	localparam logic [W_BITS-1:0] LOG_MAX = W_BITS'((64'd1 << LOG_BITS) - 64'd1);

	// ---- divider: t = ((y-1) * 2^F) / (y+1) ----
	logic [Y_BITS-1:0]    y;
	logic                 dv_valid [FRAC_BITS+1];
	logic                 dv_stall [FRAC_BITS+1];
	logic [Y_BITS:0]      dv_rem   [FRAC_BITS+1];
	logic [Y_BITS:0]      dv_den   [FRAC_BITS+1];
	logic [FRAC_BITS-1:0] dv_quot  [FRAC_BITS+1];

	assign y           = operand[Y_BITS-1:0];
	assign dv_valid[0] = in_valid;
	assign in_stall    = dv_stall[0];
	assign dv_den[0]   = (Y_BITS+1)'(y) + 1'b1;
	// zero operand: start from a zero remainder so t, and so the result, is zero
	assign dv_rem[0]   = (y == '0) ? '0 : (Y_BITS+1)'(y) - 1'b1;
	assign dv_quot[0]  = '0;

	for (genvar i = 0; i < FRAC_BITS; i++) begin : g_div
		lnat_div_stage #(
			.Y_BITS    (Y_BITS),
			.FRAC_BITS (FRAC_BITS)
		) u_div (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (dv_valid[i]),
			.up_stall (dv_stall[i]),
			.rem_up   (dv_rem[i]),
			.den_up   (dv_den[i]),
			.quot_up  (dv_quot[i]),
			.dn_valid (dv_valid[i+1]),
			.dn_stall (dv_stall[i+1]),
			.rem_dn   (dv_rem[i+1]),
			.den_dn   (dv_den[i+1]),
			.quot_dn  (dv_quot[i+1])
		);
	end

	// ---- square stage: t2 = floor(t*t / 2^F) ----
	logic                 valid_s1;
	logic [FRAC_BITS-1:0] t_s1;
	logic [FRAC_BITS-1:0] t2_s1;
	logic [SQ_BITS-1:0]   sq_prod;
	logic                 sq_stall;

	assign sq_prod           = SQ_BITS'(dv_quot[FRAC_BITS]) * SQ_BITS'(dv_quot[FRAC_BITS]);
	assign dv_stall[FRAC_BITS] = valid_s1 & sq_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!dv_stall[FRAC_BITS]) begin
			valid_s1 <= dv_valid[FRAC_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (dv_valid[FRAC_BITS] && !dv_stall[FRAC_BITS]) begin
			t_s1  <= dv_quot[FRAC_BITS];
			t2_s1 <= sq_prod[SQ_BITS-1:FRAC_BITS];
		end
	end

	// ---- Horner chain on t2, seeded with the last coefficient ----
	logic                 hn_valid [HORNER_TERMS+1];
	logic                 hn_stall [HORNER_TERMS+1];
	logic [FRAC_BITS-1:0] hn_t     [HORNER_TERMS+1];
	logic [FRAC_BITS-1:0] hn_t2    [HORNER_TERMS+1];
	logic [S_BITS-1:0]    hn_s     [HORNER_TERMS+1];

	assign hn_valid[0] = valid_s1;
	assign sq_stall    = hn_stall[0];
	assign hn_t[0]     = t_s1;
	assign hn_t2[0]    = t2_s1;
	assign hn_s[0]     = C_LEAD;

	for (genvar k = 0; k < HORNER_TERMS; k++) begin : g_horner
		lnat_horner_stage #(
			.FRAC_BITS (FRAC_BITS),
			.DIVISOR   (HORNER_DIV[k])
		) u_horner (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (hn_valid[k]),
			.up_stall (hn_stall[k]),
			.t_up     (hn_t[k]),
			.t2_up    (hn_t2[k]),
			.s_up     (hn_s[k]),
			.dn_valid (hn_valid[k+1]),
			.dn_stall (hn_stall[k+1]),
			.t_dn     (hn_t[k+1]),
			.t2_dn    (hn_t2[k+1]),
			.s_dn     (hn_s[k+1])
		);
	end

	// ---- final product: floor(t * 2s / 2^F) ----
	logic               valid_s2;
	logic [R_BITS-1:0]  res_s2;
	logic [FP_BITS-1:0] fin_prod;
	logic               fin_stall;

	assign fin_prod               = FP_BITS'(hn_t[HORNER_TERMS])
	                                * FP_BITS'({hn_s[HORNER_TERMS], 1'b0});
	assign hn_stall[HORNER_TERMS] = valid_s2 & fin_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!hn_stall[HORNER_TERMS]) begin
			valid_s2 <= hn_valid[HORNER_TERMS];
		end
	end

	always_ff @(posedge clk) begin
		if (hn_valid[HORNER_TERMS] && !hn_stall[HORNER_TERMS]) begin
			res_s2 <= fin_prod[FP_BITS-1:FRAC_BITS];
		end
	end

	// ---- output register with saturation ----
	logic                valid_s3;
	logic [LOG_BITS-1:0] log_s3;
	logic [W_BITS-1:0]   res_wide;

	assign res_wide  = W_BITS'(res_s2);
	assign fin_stall = valid_s3 & out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (!fin_stall) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s2 && !fin_stall) begin
			log_s3 <= (res_wide > LOG_MAX) ? LOG_MAX[LOG_BITS-1:0] : res_wide[LOG_BITS-1:0];
		end
	end

	assign out_valid = valid_s3;
	assign log_value = log_s3;

endmodule

// ----- rtl/natural_log_atanh_series_chk.sv -----
// ----------------------------------------------------------------------------
// natural_log_atanh_series_chk
// Port-level checks for the logarithm pipeline, bound to the top level.
// ----------------------------------------------------------------------------
module natural_log_atanh_series_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              in_valid,
	input logic                              in_stall,
	input logic [lnat_pkg::OPERAND_BITS-1:0] operand,
	input logic                              out_valid,
	input logic                              out_stall,
	input logic [lnat_pkg::LOG_BITS-1:0]     log_value
);

	// input may only back up when the result register is held
	a_stall_from_output: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled while output is free");

	// no result can appear in the cycle just after reset is released
	a_empty_after_reset: assert property (@(posedge clk)
		!$past(arst_n) |-> !out_valid)
		else $error("result present straight after reset");

	// a stalled request stays offered and unchanged
	a_in_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |=> (in_valid && $stable(operand)))
		else $error("request changed while stalled");

	a_out_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid)
		else $error("result dropped while stalled");

	a_out_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> $stable(log_value))
		else $error("result changed while stalled");

endmodule

bind natural_log_atanh_series natural_log_atanh_series_chk u_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.operand   (operand),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.log_value (log_value)
);
